### hw/rtl/wsfr_pkg.sv
package wsfr_pkg;

  // payload length register width and the largest length that is accepted
  localparam int LenW       = 64;
  localparam int LengthBits = 64;
  localparam logic [LenW-1:0] LenFitMask =
    (LengthBits >= LenW) ? {LenW{1'b1}} : ((LenW'(1) << LengthBits) - LenW'(1));

  // header bit fields and length codes
  localparam logic [7:0] HdrTopBit  = 8'h80;
  localparam logic [7:0] OpMask     = 8'h0f;
  localparam logic [7:0] Len7Mask   = 8'h7f;
  localparam logic [6:0] Len7Ext16  = 7'd126;
  localparam logic [6:0] Len7Ext64  = 7'd127;
  localparam logic [LenW-1:0] CtrlMaxLen = LenW'(125);

  // extended length byte counts
  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;

  // opcodes
  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PING  = 4'd9;
  localparam logic [3:0] OP_PONG  = 4'd10;

  // event codes
  localparam logic [2:0] EV_DATA  = 3'd0;
  localparam logic [2:0] EV_PING  = 3'd1;
  localparam logic [2:0] EV_PONG  = 3'd2;
  localparam logic [2:0] EV_CLOSE = 3'd3;
  localparam logic [2:0] EV_ERROR = 3'd4;

  // error codes
  localparam logic [2:0] ERR_UNMASKED  = 3'd0;
  localparam logic [2:0] ERR_BAD_CTRL  = 3'd1;
  localparam logic [2:0] ERR_BAD_CLOSE = 3'd2;
  localparam logic [2:0] ERR_STRAY     = 3'd3;
  localparam logic [2:0] ERR_TOO_BIG   = 3'd4;

  localparam logic [15:0] CloseDefault = 16'd1000;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef struct packed {
    logic [2:0]  fault_code;
    logic [15:0] close_status;
    logic        message_end;
    logic        frame_end;
    logic [3:0]  message_type;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic [2:0]  event_res;
  } res_t;

endpackage

### hw/rtl/websocket_frame_receiver_top.sv
// websocket frame receiver, client-to-server direction
// in_* channel: one stream byte per item in in_tdata, taken when in_tvalid
//   and in_tready are both high
// out_* channel: zero or one result item per input byte; event kind and
//   byte_valid in out_tuser, frame end on out_tlast, the rest in out_tdata
// cfg_*: max_payload write, always ready; user writes only while idle
//   (not checked by the block); results pass the output or skid register
// throughput: one byte per cycle while in_tready is high; header, mask and
//   payload bytes each pass through combinational header/payload logic
//   between the state registers and the output register
// stall: a two-entry output stage (output register plus skid register) lets
//   in_tready stay high for one more item while out_tready is low; in_tready
//   falls only when both entries hold results
// reset: rst_n low clears the parser to expect a new frame header, empties
//   the output stage and sets max_payload to zero (no limit)
// after a close frame or any protocol error every further byte is taken and
//   dropped until the next reset
module websocket_frame_receiver_top
  import wsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,      // max_payload
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // in_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // data_byte, message_type, message_end,
                                     // close_status, fault_code
  output logic [3:0]  out_tuser,     // event_res, byte_valid
  output logic        out_tlast      // frame_end
);

  // state registers
  logic [31:0]     max_r;
  phase_t          phase_r, phase_nxt;
  logic            fin_r, fin_nxt;
  logic [3:0]      op_r, op_nxt;
  logic [3:0]      ext_cnt_r, ext_cnt_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [LenW-1:0] idx_r, idx_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [1:0]      mask_cnt_r, mask_cnt_nxt;
  logic            frag_act_r, frag_act_nxt;
  logic [3:0]      frag_type_r, frag_type_nxt;
  logic [15:0]     status_r, status_nxt;
  logic            closed_r, closed_nxt;

  // output stage
  logic            out_valid_r, skid_valid_r;
  res_t            out_r, skid_r;

  // per-item combinational values
  logic            in_acc;
  logic [7:0]      b;
  res_t            res;
  logic            res_vld;
  logic            hdr_done;
  logic [LenW-1:0] len_c;
  logic [LenW-1:0] idx_inc;
  logic            last;
  logic [7:0]      key_byte;
  logic [7:0]      pb;
  logic [3:0]      cur_type;
  logic            ctrl;
  logic            fits;
  logic [15:0]     status_lo;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.fault_code, out_r.close_status, out_r.message_end,
                       out_r.message_type, out_r.data_byte};
  assign out_tuser  = {out_r.byte_valid, out_r.event_res};
  assign out_tlast  = out_r.frame_end;

  // payload unmasking and frame position
  assign idx_inc = idx_r + LenW'(1);
  assign last    = (idx_inc == len_r);
  always_comb begin
    case (idx_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end
  assign pb        = b ^ key_byte;
  assign cur_type  = (op_r == OP_CONT || !fin_r) ? frag_type_r : op_r;
  assign ctrl      = op_r[3];
  assign status_lo = {status_r[15:8], pb};

  // parser next state and result
  always_comb begin
    phase_nxt     = phase_r;
    fin_nxt       = fin_r;
    op_nxt        = op_r;
    ext_cnt_nxt   = ext_cnt_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    mask_cnt_nxt  = mask_cnt_r;
    frag_act_nxt  = frag_act_r;
    frag_type_nxt = frag_type_r;
    status_nxt    = status_r;
    closed_nxt    = closed_r;
    res           = '0;
    res_vld       = 1'b0;
    hdr_done      = 1'b0;
    len_c         = len_r;
    fits          = 1'b1;

    if (in_acc && !closed_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          fin_nxt   = |(b & HdrTopBit);
          op_nxt    = 4'(b & OpMask);
          phase_nxt = PH_HDR1;
        end
        PH_HDR1: begin
          if (!(|(b & HdrTopBit))) begin
            closed_nxt     = 1'b1;
            res_vld        = 1'b1;
            res.event_res  = EV_ERROR;
            res.fault_code = ERR_UNMASKED;
          end else begin
            len_nxt = '0;
            if (7'(b & Len7Mask) == Len7Ext16) begin
              ext_cnt_nxt = ExtBytes16;
              phase_nxt   = PH_EXT;
            end else if (7'(b & Len7Mask) == Len7Ext64) begin
              ext_cnt_nxt = ExtBytes64;
              phase_nxt   = PH_EXT;
            end else begin
              len_c    = LenW'(b & Len7Mask);
              len_nxt  = len_c;
              hdr_done = 1'b1;
            end
          end
        end
        PH_EXT: begin
          len_c       = {len_r[LenW-9:0], b};
          len_nxt     = len_c;
          ext_cnt_nxt = ext_cnt_r - 4'd1;
          hdr_done    = (ext_cnt_r <= 4'd1);
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], b};
          if (mask_cnt_r == 2'd3) begin
            mask_cnt_nxt = 2'd0;
            if (len_r == '0) begin
              // empty frame gives its result on the last mask byte
              phase_nxt     = PH_HDR0;
              res_vld       = 1'b1;
              res.frame_end = 1'b1;
              case (op_r)
                OP_CLOSE: begin
                  closed_nxt       = 1'b1;
                  res.event_res    = EV_CLOSE;
                  res.close_status = CloseDefault;
                end
                OP_PING: res.event_res = EV_PING;
                OP_PONG: res.event_res = EV_PONG;
                default: begin
                  res.event_res    = EV_DATA;
                  res.message_type = cur_type;
                  res.message_end  = fin_r;
                  if (op_r == OP_CONT && fin_r) frag_act_nxt = 1'b0;
                end
              endcase
            end else begin
              phase_nxt = PH_PAYLOAD;
              idx_nxt   = '0;
            end
          end else begin
            mask_cnt_nxt = mask_cnt_r + 2'd1;
          end
        end
        PH_PAYLOAD: begin
          idx_nxt = last ? '0 : idx_inc;
          if (last) phase_nxt = PH_HDR0;
          case (op_r)
            OP_CLOSE: begin
              if (idx_r == '0) begin
                status_nxt = {pb, 8'd0};
              end else if (idx_r == LenW'(1)) begin
                status_nxt = status_lo;
                if (last) begin
                  res_vld          = 1'b1;
                  res.event_res    = EV_CLOSE;
                  res.frame_end    = 1'b1;
                  res.close_status = status_lo;
                end
              end else begin
                res_vld          = 1'b1;
                res.event_res    = EV_CLOSE;
                res.byte_valid   = 1'b1;
                res.data_byte    = pb;
                res.frame_end    = last;
                res.close_status = status_r;
              end
              if (last) closed_nxt = 1'b1;
            end
            OP_PING: begin
              res_vld        = 1'b1;
              res.event_res  = EV_PING;
              res.byte_valid = 1'b1;
              res.data_byte  = pb;
              res.frame_end  = last;
            end
            OP_PONG: begin
              // pong payload is dropped, only the end event comes out
              res_vld       = last;
              res.event_res = EV_PONG;
              res.frame_end = 1'b1;
            end
            default: begin
              res_vld          = 1'b1;
              res.event_res    = EV_DATA;
              res.byte_valid   = 1'b1;
              res.data_byte    = pb;
              res.message_type = cur_type;
              res.frame_end    = last;
              res.message_end  = last && fin_r;
              if (last && op_r == OP_CONT && fin_r) frag_act_nxt = 1'b0;
            end
          endcase
        end
        default: phase_nxt = PH_HDR0;
      endcase

      // frame checks once the length is complete
      if (hdr_done) begin
        fits = ((len_c & ~LenFitMask) == '0);
        res.event_res = EV_ERROR;
        if (ctrl && (!fin_r || len_c > CtrlMaxLen)) begin
          closed_nxt     = 1'b1;
          res_vld        = 1'b1;
          res.fault_code = ERR_BAD_CTRL;
        end else if (!fits ||
                     (max_r != 32'd0 && len_c > {{(LenW-32){1'b0}}, max_r})) begin
          closed_nxt     = 1'b1;
          res_vld        = 1'b1;
          res.fault_code = ERR_TOO_BIG;
        end else if (op_r == OP_CLOSE && len_c == LenW'(1)) begin
          closed_nxt     = 1'b1;
          res_vld        = 1'b1;
          res.fault_code = ERR_BAD_CLOSE;
        end else if (op_r == OP_CONT && !frag_act_r) begin
          closed_nxt     = 1'b1;
          res_vld        = 1'b1;
          res.fault_code = ERR_STRAY;
        end else begin
          res.event_res = EV_DATA;
          if (!ctrl && op_r != OP_CONT && !fin_r && !frag_act_r) begin
            frag_act_nxt  = 1'b1;
            frag_type_nxt = op_r;
          end
          phase_nxt    = PH_MASK;
          mask_cnt_nxt = 2'd0;
          idx_nxt      = '0;
        end
      end
    end
  end

  // parser state and config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r       <= 32'd0;
      phase_r     <= PH_HDR0;
      fin_r       <= 1'b0;
      op_r        <= OP_CONT;
      ext_cnt_r   <= 4'd0;
      len_r       <= '0;
      idx_r       <= '0;
      key_r       <= 32'd0;
      mask_cnt_r  <= 2'd0;
      frag_act_r  <= 1'b0;
      frag_type_r <= 4'd0;
      status_r    <= 16'd0;
      closed_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) max_r <= cfg_data;
      phase_r     <= phase_nxt;
      fin_r       <= fin_nxt;
      op_r        <= op_nxt;
      ext_cnt_r   <= ext_cnt_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      key_r       <= key_nxt;
      mask_cnt_r  <= mask_cnt_nxt;
      frag_act_r  <= frag_act_nxt;
      frag_type_r <= frag_type_nxt;
      status_r    <= status_nxt;
      closed_r    <= closed_nxt;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_vld;
      end
    end else if (res_vld) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_vld) begin
      skid_r <= res;
    end
  end

endmodule
